// ===== rtl/core/mmcs_pkg.sv =====
// mmcs_pkg: shared types and constants of the min-max contrast stretch block
// used by every module under rtl/core; depends on nothing else
`timescale 1ns / 1ps

package mmcs_pkg;

  // widths fixed by the stream fields
  localparam int SAMPLE_BITS  = 8;
  localparam int NUM_CHANNELS = 3;
  localparam int CH_BITS      = 2;
  localparam int NUM_BITS     = 2 * SAMPLE_BITS + 1;  // signed (s - min) * max_value
  localparam int DEN_BITS     = SAMPLE_BITS + 1;      // signed max - min

  // register map, byte address = 4 * index
  localparam logic REG_MAX_VALUE = 1'b0;

  localparam logic [SAMPLE_BITS-1:0] MAX_VALUE_RESET = 8'd255;
  localparam logic [SAMPLE_BITS-1:0] STAT_MIN_RESET  = 8'd255;
  localparam logic [SAMPLE_BITS-1:0] STAT_MAX_RESET  = 8'd0;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_MEASURE = 2'd1,
    FUNC_MAP     = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  // one map job handed from the front end to the divider
  typedef struct packed {
    logic                        imm;   // result known, no division
    logic                        flat;  // channel max equals min
    logic signed [NUM_BITS-1:0]  num;
    logic signed [DEN_BITS-1:0]  den;
    logic [SAMPLE_BITS-1:0]      mv;
  } mmcs_job_t;

  // divider sequencer states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_HOLD = 2'd2
  } bk_state_t;

endpackage

// ===== rtl/core/min_max_contrast_stretch.sv =====
// Min-max contrast stretch: clear, measure and map items for three channels. Clear and
// measure act on the channel statistics when accepted and yield no output transaction. A
// map item yields one output transaction; when the divide is needed it passes stats
// lookup, multiply, job decode, 8 restoring divide steps on one shared divider and result
// load, and the divider takes a new map job only once its last result is loaded. Maps of a
// flat channel, of channel three or with a negative or saturating result skip the divide.
// A two-entry job queue lets input keep flowing while a result waits at the output.
// min_max_contrast_stretch: top level, APB register and stream ports; uses mmcs_pkg,
// mmcs_front, mmcs_queue and mmcs_back
`timescale 1ns / 1ps

module min_max_contrast_stretch (
  input  logic        clk,
  input  logic        rst,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic [3:0]  s_tuser,   // [1:0] func, [3:2] channel
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] mapped_sample
  output logic        m_tuser    // [0] flat_channel
);

  logic [mmcs_pkg::SAMPLE_BITS-1:0] max_value;
  logic                             reg_hit;
  logic                             job_valid;
  logic                             job_ready;
  mmcs_pkg::mmcs_job_t              job_in;
  logic                             q_valid;
  logic                             q_ready;
  mmcs_pkg::mmcs_job_t              q_job;

  // register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == mmcs_pkg::REG_MAX_VALUE);
  assign prdata  = reg_hit ? {24'd0, max_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value <= mmcs_pkg::MAX_VALUE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_value <= pwdata[mmcs_pkg::SAMPLE_BITS-1:0];
    end
  end

  mmcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .func      (s_tuser[1:0]),
    .channel   (s_tuser[3:2]),
    .sample    (s_tdata),
    .max_value (max_value),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job_in)
  );

  mmcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  mmcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job        (q_job),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (m_tdata),
    .out_flat   (m_tuser)
  );

endmodule

// ===== rtl/core/mmcs_front.sv =====
// mmcs_front: accepts stream transactions, keeps per-channel min/max and
// builds map jobs (numerator and denominator); uses mmcs_pkg
`timescale 1ns / 1ps

module mmcs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         func,
  input  logic [mmcs_pkg::CH_BITS-1:0]       channel,
  input  logic [mmcs_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic [mmcs_pkg::SAMPLE_BITS-1:0]   max_value,
  output logic                               job_valid,
  input  logic                               job_ready,
  output mmcs_pkg::mmcs_job_t                job
);

  logic [mmcs_pkg::SAMPLE_BITS-1:0] channel_min [mmcs_pkg::NUM_CHANNELS];
  logic [mmcs_pkg::SAMPLE_BITS-1:0] channel_max [mmcs_pkg::NUM_CHANNELS];

  // stage register between stats lookup and multiply
  logic                                    st_valid;
  logic                                    st_imm;
  logic                                    st_flat;
  logic signed [mmcs_pkg::DEN_BITS-1:0]    st_diff;
  logic signed [mmcs_pkg::DEN_BITS-1:0]    st_den;

  logic                                    accept;
  logic                                    ch_ok;
  logic [mmcs_pkg::SAMPLE_BITS-1:0]        cur_min;
  logic [mmcs_pkg::SAMPLE_BITS-1:0]        cur_max;
  logic signed [mmcs_pkg::DEN_BITS-1:0]    diff;
  logic signed [mmcs_pkg::DEN_BITS-1:0]    den;
  logic signed [2*mmcs_pkg::DEN_BITS-1:0]  product;
  mmcs_pkg::func_t                         op;

  assign op       = mmcs_pkg::func_t'(func);
  assign in_ready = !st_valid || job_ready;
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (channel < 2'(mmcs_pkg::NUM_CHANNELS));

  // stats lookup for the addressed channel
  always_comb begin
    cur_min = mmcs_pkg::STAT_MIN_RESET;
    cur_max = mmcs_pkg::STAT_MAX_RESET;
    if (ch_ok) begin
      cur_min = channel_min[channel];
      cur_max = channel_max[channel];
    end
    diff = $signed({1'b0, sample}) - $signed({1'b0, cur_min});
    den  = $signed({1'b0, cur_max}) - $signed({1'b0, cur_min});
  end

  // clear and measure act at once, no transaction leaves for them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < mmcs_pkg::NUM_CHANNELS; c++) begin
        channel_min[c] <= mmcs_pkg::STAT_MIN_RESET;
        channel_max[c] <= mmcs_pkg::STAT_MAX_RESET;
      end
    end else if (accept) begin
      case (op)
        mmcs_pkg::FUNC_CLEAR: begin
          for (int c = 0; c < mmcs_pkg::NUM_CHANNELS; c++) begin
            channel_min[c] <= mmcs_pkg::STAT_MIN_RESET;
            channel_max[c] <= mmcs_pkg::STAT_MAX_RESET;
          end
        end
        mmcs_pkg::FUNC_MEASURE: begin
          if (ch_ok) begin
            if (sample > cur_max) channel_max[channel] <= sample;
            if (sample < cur_min) channel_min[channel] <= sample;
          end
        end
        default: ;
      endcase
    end
  end

  // map items wait here for the multiply and the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= (op == mmcs_pkg::FUNC_MAP);
    end else if (job_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_imm  <= !ch_ok || (den == '0);
      st_flat <= ch_ok && (den == '0);
      st_diff <= diff;
      st_den  <= den;
    end
  end

  // multiply before divide
  assign product = st_diff * $signed({1'b0, max_value});

  always_comb begin
    job_valid = st_valid;
    job.imm   = st_imm;
    job.flat  = st_flat;
    job.num   = product[mmcs_pkg::NUM_BITS-1:0];
    job.den   = st_den;
    job.mv    = max_value;
  end

endmodule

// ===== rtl/core/mmcs_queue.sv =====
// mmcs_queue: two-entry job queue between front end and divider
// uses mmcs_pkg for the job type
`timescale 1ns / 1ps

module mmcs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  mmcs_pkg::mmcs_job_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mmcs_pkg::mmcs_job_t pop_data
);

  mmcs_pkg::mmcs_job_t slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue fill level out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

// ===== rtl/core/mmcs_back.sv =====
// mmcs_back: sign handling, saturation and 8-step restoring divider,
// with the output register of the result stream; uses mmcs_pkg
`timescale 1ns / 1ps

module mmcs_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               job_valid,
  output logic                               job_ready,
  input  mmcs_pkg::mmcs_job_t                job,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mmcs_pkg::SAMPLE_BITS-1:0]   out_sample,
  output logic                               out_flat
);

  localparam int SB = mmcs_pkg::SAMPLE_BITS;

  mmcs_pkg::bk_state_t state;
  mmcs_pkg::bk_state_t state_next;

  logic [SB-1:0]          rem;
  logic [SB-1:0]          dvd;
  logic [SB-1:0]          dmag;
  logic [SB-1:0]          mv;
  logic [SB-1:0]          res;
  logic                   res_flat;
  logic [$clog2(SB)-1:0]  cnt;

  logic                   take;
  logic                   load_out;
  logic                   num_neg;
  logic                   den_neg;
  logic [mmcs_pkg::NUM_BITS-1:0] num_abs;
  logic [mmcs_pkg::DEN_BITS-1:0] den_abs;
  logic [2*SB-1:0]        nmag;
  logic [SB-1:0]          dmag_in;
  logic [SB:0]            trial;
  logic                   fits;
  logic [SB-1:0]          quot;

  // magnitudes and signs of the incoming job
  always_comb begin
    num_neg = job.num[mmcs_pkg::NUM_BITS-1];
    den_neg = job.den[mmcs_pkg::DEN_BITS-1];
    num_abs = num_neg ? -job.num : job.num;
    den_abs = den_neg ? -job.den : job.den;
    nmag    = num_abs[2*SB-1:0];
    dmag_in = den_abs[SB-1:0];
  end

  // one restoring step
  always_comb begin
    trial = {rem, dvd[SB-1]};
    fits  = (trial >= {1'b0, dmag});
    quot  = {dvd[SB-2:0], fits};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mmcs_pkg::BK_IDLE: begin
        if (job_valid) begin
          if (job.imm || job.num == '0 || num_neg != den_neg || nmag[2*SB-1:SB] >= dmag_in)
            state_next = mmcs_pkg::BK_HOLD;
          else
            state_next = mmcs_pkg::BK_DIV;
        end
      end
      mmcs_pkg::BK_DIV:  if (cnt == '1) state_next = mmcs_pkg::BK_HOLD;
      mmcs_pkg::BK_HOLD: if (!out_valid || out_ready) state_next = mmcs_pkg::BK_IDLE;
      default:           state_next = mmcs_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take     = 1'b0;
    load_out = 1'b0;
    case (state)
      mmcs_pkg::BK_IDLE: take     = job_valid;
      mmcs_pkg::BK_HOLD: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign job_ready = take;

  always_ff @(posedge clk) begin
    if (rst) state <= mmcs_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // job decode and divider datapath
  always_ff @(posedge clk) begin
    if (take) begin
      mv       <= job.mv;
      dmag     <= dmag_in;
      rem      <= nmag[2*SB-1:SB];
      dvd      <= nmag[SB-1:0];
      cnt      <= '0;
      res_flat <= job.flat;
      if (job.imm || job.num == '0 || num_neg != den_neg)
        res <= '0;
      else
        res <= job.mv;
    end else if (state == mmcs_pkg::BK_DIV) begin
      rem <= fits ? (trial[SB-1:0] - dmag) : trial[SB-1:0];
      dvd <= quot;
      cnt <= cnt + 1'b1;
      if (cnt == '1) res <= (quot > mv) ? mv : quot;
    end
  end

  // result register, frees the divider while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= res;
      out_flat   <= res_flat;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == mmcs_pkg::BK_DIV) |-> (rem < dmag))
    else $error("divider remainder not below divisor");
  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_flat) |-> (out_sample == '0))
    else $error("flat channel result not zero");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> (state == mmcs_pkg::BK_IDLE))
    else $error("job taken while divider busy");
`endif

endmodule

// ===== verif/mmcs_stretch_monitor.sv =====
// mmcs_stretch_monitor: watches the register port and both streams of the contrast
// stretch block, predicts every mapped sample and compares it; depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_stretch_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic [3:0]  s_tuser,   // [1:0] func, [3:2] channel
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] mapped_sample
  input  logic        m_tuser,   // [0] flat_channel
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [mmcs_pkg::SAMPLE_BITS-1:0] level;
    logic                             flat;
  } stretch_res_t;

  // running statistics and target range, mirrored from the accepted transactions
  logic [mmcs_pkg::SAMPLE_BITS-1:0] ch_lo [mmcs_pkg::NUM_CHANNELS];
  logic [mmcs_pkg::SAMPLE_BITS-1:0] ch_hi [mmcs_pkg::NUM_CHANNELS];
  logic [mmcs_pkg::SAMPLE_BITS-1:0] range_top;
  stretch_res_t                     expected_pixels [$];
  int                               mismatches;

  task automatic clear_stats();
    for (int c = 0; c < mmcs_pkg::NUM_CHANNELS; c++) begin
      ch_lo[c] = mmcs_pkg::STAT_MIN_RESET;
      ch_hi[c] = mmcs_pkg::STAT_MAX_RESET;
    end
  endtask

  // stretched value of one sample: multiply first, quotient truncated toward zero
  function automatic stretch_res_t stretch_pixel(
      input logic [1:0]                       chan,
      input logic [mmcs_pkg::SAMPLE_BITS-1:0] smp);
    stretch_res_t r;
    int           span;
    int           scaled;
    int           q;
    r = '0;
    if (chan >= mmcs_pkg::NUM_CHANNELS) return r;
    span = int'(ch_hi[chan]) - int'(ch_lo[chan]);
    if (span == 0) begin
      r.flat = 1'b1;
      return r;
    end
    scaled = (int'(smp) - int'(ch_lo[chan])) * int'(range_top);
    q = scaled / span;
    if (q < 0) q = 0;
    if (q > int'(range_top)) q = int'(range_top);
    r.level = q[mmcs_pkg::SAMPLE_BITS-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    stretch_res_t      got;
    stretch_res_t      want;
    mmcs_pkg::func_t   op;
    logic [1:0]        chan;
    if (rst) begin
      clear_stats();
      range_top = mmcs_pkg::MAX_VALUE_RESET;
      expected_pixels.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready &&
          paddr == {mmcs_pkg::REG_MAX_VALUE, 2'b00})
        range_top = pwdata[mmcs_pkg::SAMPLE_BITS-1:0];

      // result transaction against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.level = m_tdata;
        got.flat  = m_tuser;
        if (expected_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected result: mapped_sample %0d flat_channel %0d",
                                  got.level, got.flat));
        end else begin
          want = expected_pixels.pop_front();
          if (got.level !== want.level || got.flat !== want.flat)
            note_mismatch($sformatf({"result mismatch: mapped_sample exp %0d got %0d, ",
                                     "flat_channel exp %0d got %0d"},
                                    want.level, got.level, want.flat, got.flat));
        end
      end

      // input transaction
      if (s_tvalid && s_tready) begin
        op   = mmcs_pkg::func_t'(s_tuser[1:0]);
        chan = s_tuser[3:2];
        case (op)
          mmcs_pkg::FUNC_CLEAR: begin
            clear_stats();
          end
          mmcs_pkg::FUNC_MEASURE: begin
            if (chan < mmcs_pkg::NUM_CHANNELS) begin
              if (s_tdata > ch_hi[chan]) ch_hi[chan] = s_tdata;
              if (s_tdata < ch_lo[chan]) ch_lo[chan] = s_tdata;
            end
          end
          mmcs_pkg::FUNC_MAP: begin
            expected_pixels.push_back(stretch_pixel(chan, s_tdata));
          end
          default: ;
        endcase
      end
    end
    pending    <= expected_pixels.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/tb_min_max_contrast_stretch.sv =====
// tb_min_max_contrast_stretch: stimulus and verdict for the contrast stretch block
// drives clear, measure and map transactions under several range settings;
// depends on mmcs_pkg, min_max_contrast_stretch and mmcs_stretch_monitor
`timescale 1ns / 1ps

module tb_min_max_contrast_stretch;

  localparam int RUN_LIMIT   = 500000;
  localparam int RX_HOLD_LEN = 400;
  localparam int SETTLE_LEN  = 24;
  localparam int PHASE_ITEMS = 75;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] sample
  logic [3:0]  s_tuser;   // [1:0] func, [3:2] channel
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] mapped_sample
  logic        m_tuser;   // [0] flat_channel

  int fail_count;
  int pending;
  int items_sent;
  int cycles;
  bit quiet;
  bit rx_hold_req;

  min_max_contrast_stretch u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mmcs_stretch_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("min_max_contrast_stretch regression: fail");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver side: random back-pressure plus one long hold on request
  initial begin : rx_side
    int idle;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_LEN) @(negedge clk);
      end else begin
        idle = gap_len();
        if (idle > 0) begin
          m_tready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(6, 0)) @(negedge clk);
      end
    end
  end

  // one input transaction, waits for acceptance
  task automatic push_item(input mmcs_pkg::func_t op, input logic [1:0] chan,
                           input logic [7:0] smp);
    int idle;
    idle = gap_len();
    @(negedge clk);
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= {chan, op};
    do @(posedge clk); while (!s_tready);
    if (op != mmcs_pkg::FUNC_NOP) items_sent++;
  endtask

  // sender stops until every expected result is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic set_range_top(input logic [7:0] level);
    settle();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {mmcs_pkg::REG_MAX_VALUE, 2'b00};
    pwdata  <= {24'd0, level};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // clear, a few measures within one band, then maps; some frames broken or noisy
  task automatic run_frame();
    int         lo;
    int         hi;
    int         r;
    logic [1:0] chan;
    logic [7:0] smp;
    if ($urandom_range(9, 0) != 0)
      push_item(mmcs_pkg::FUNC_CLEAR, 2'($urandom), 8'($urandom));
    lo = $urandom_range(255, 0);
    hi = $urandom_range(255, lo);
    repeat ($urandom_range(6, 1))
      push_item(mmcs_pkg::FUNC_MEASURE, 2'($urandom_range(2, 0)),
                8'($urandom_range(hi, lo)));
    repeat ($urandom_range(8, 2)) begin
      r = $urandom_range(9, 0);
      if (r == 0) begin
        push_item(mmcs_pkg::func_t'($urandom_range(3, 0)), 2'($urandom), 8'($urandom));
      end else begin
        chan = (r == 1) ? 2'd3 : 2'($urandom_range(2, 0));
        smp  = (r == 2) ? 8'($urandom) : 8'($urandom_range(hi, lo));
        push_item(mmcs_pkg::FUNC_MAP, chan, smp);
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] tops [6];
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    quiet       = 1'b0;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: unmeasured channels, channel three, no-op, flat, clamping both ways
    push_item(mmcs_pkg::FUNC_MAP,     2'd0, 8'd0);
    push_item(mmcs_pkg::FUNC_MAP,     2'd0, 8'd255);
    push_item(mmcs_pkg::FUNC_MAP,     2'd1, 8'd128);
    push_item(mmcs_pkg::FUNC_MAP,     2'd3, 8'd77);
    push_item(mmcs_pkg::FUNC_NOP,     2'd1, 8'hAA);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd3, 8'd5);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd0, 8'd0);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd0, 8'd255);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd1, 8'd100);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd2, 8'd10);
    push_item(mmcs_pkg::FUNC_MEASURE, 2'd2, 8'd200);
    push_item(mmcs_pkg::FUNC_MAP,     2'd0, 8'd0);
    push_item(mmcs_pkg::FUNC_MAP,     2'd0, 8'd255);
    push_item(mmcs_pkg::FUNC_MAP,     2'd0, 8'd128);
    push_item(mmcs_pkg::FUNC_MAP,     2'd1, 8'd100);
    push_item(mmcs_pkg::FUNC_MAP,     2'd1, 8'd50);
    push_item(mmcs_pkg::FUNC_MAP,     2'd2, 8'd5);
    push_item(mmcs_pkg::FUNC_MAP,     2'd2, 8'd250);
    push_item(mmcs_pkg::FUNC_MAP,     2'd2, 8'd100);
    push_item(mmcs_pkg::FUNC_CLEAR,   2'd3, 8'hFF);
    push_item(mmcs_pkg::FUNC_MAP,     2'd2, 8'd100);
    push_item(mmcs_pkg::FUNC_NOP,     2'd3, 8'h55);

    // random phases over range settings, extremes and a zero range among them
    tops = '{8'd1, 8'd255, 8'd0, 8'd128, 8'($urandom_range(254, 2)), 8'($urandom)};
    items_sent = 0;
    for (int p = 0; p < 6; p++) begin
      set_range_top(tops[p]);
      quiet = (p == 3);
      if (p == 1) begin
        // receiver holds off while the sender keeps offering maps
        rx_hold_req = 1'b1;
        repeat (4) run_frame();
      end
      while (items_sent < (p + 1) * PHASE_ITEMS) run_frame();
      quiet = 1'b0;
    end

    // drain
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("min_max_contrast_stretch regression: pass");
    end else begin
      $display("min_max_contrast_stretch regression: fail");
    end
    $finish;
  end

endmodule
